@@ hw/rtl/irp_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the record permuter.
`default_nettype none

package irp_pkg;

  // Store geometry
  localparam int DEPTH        = 1024;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_W        = $clog2(DEPTH);

  // Field widths
  localparam int OP_W        = 2;
  localparam int SLOT_W      = 10;
  localparam int DEST_W      = 10;
  localparam int PAYLOAD_W   = 64;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 11;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;

  // Counter width: holds both the node count and DEPTH itself
  localparam int N_W = (CNT_W > $clog2(DEPTH + 1)) ? CNT_W : $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_PERMUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_DUP        = 2'd1,
    ST_DEST_RANGE = 2'd2,
    ST_SLOT_RANGE = 2'd3
  } status_t;

  // Read address source, shared by all three stores
  typedef enum logic [2:0] {
    RD_IN,
    RD_ITEM,
    RD_IDX,
    RD_D,
    RD_DEST_Q
  } rd_sel_t;

  // Write address source, shared by all three stores
  typedef enum logic [1:0] {
    WR_ITEM,
    WR_IDX,
    WR_D
  } wr_sel_t;

  typedef struct packed {
    logic    accept;      // capture the input word
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    rec_we;
    logic    rec_wcur;    // record write data from carried record, else item payload
    logic    dest_we;
    logic    seen_we;
    logic    seen_wdata;
    logic    idx_clr;
    logic    idx_inc;
    logic    d_load;      // d <= destination read data
    logic    cur_load;    // carried record <= record read data
    logic    res_load;    // load the output register
    logic    res_use_rec; // result payload from record read data, else zero
    status_t res_status;
  } irp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic slot_oob;     // item slot >= n
    logic dest_oob;     // item destination >= n
    logic idx_at_n;
    logic idx_at_depth;
    logic dq_oob;       // destination read data >= n
    logic dq_eq_idx;    // destination read data == idx
    logic seen_q;
    logic out_free;
  } irp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/in_place_record_permuter_top.sv @@
// Top level of the in-place record permuter: controller plus datapath.
//
// Input stream (in_*): one word per command. in_tuser carries the op (0 load slot,
// 1 permute, 2 read slot, 3 no-op); in_tdata carries slot_index, destination, payload.
// Output stream (out_*): exactly one word per input word, in order, with read_payload
// and status. cfg_wr_en/cfg_wr_data write node_count; the user must write it only
// while the block is idle, as the block itself does not enforce this. Load, read and
// no-op words pass an accept state, then one store access through the registered-read
// RAM port. A permute is run by one state machine over single-port-per-direction RAMs:
// a check of each slot (destination range, then seen bit), a sweep that clears the
// seen bits, then the move, which walks each cycle from its leader slot and closes
// each cycle longer than one on that leader, and a second clearing sweep; an invalid
// order stops the check at the bad slot and skips the move. After reset the seen store
// is cleared with in_tready low; node_count resets to 1024. A result waits in the
// output register while out_tready is low; the next word is still accepted and runs
// until its own result is due.
`default_nettype none

module in_place_record_permuter_top
  import irp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] slot_index, [19:10] destination,
                                                  // [83:20] payload, [87:84] zero
  input  wire logic [OP_W-1:0]        in_tuser,   // [1:0] op
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [63:0] read_payload, [65:64] status,
                                                  // [71:66] zero
  input  wire logic                   cfg_wr_en,
  input  wire logic [CNT_W-1:0]       cfg_wr_data
);

  irp_cmd_t  cmd;
  irp_stat_t stat;

  irp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  irp_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_tuser),
    .in_slot     (in_tdata[SLOT_W-1:0]),
    .in_dest     (in_tdata[SLOT_W+DEST_W-1:SLOT_W]),
    .in_payload  (in_tdata[SLOT_W+DEST_W+PAYLOAD_W-1:SLOT_W+DEST_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/irp_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module irp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a same-edge write is seen on the following read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/irp_dpath.sv @@
// Datapath: record, destination and seen stores, index/carry registers, output register.
`default_nettype none

module irp_dpath
  import irp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [OP_W-1:0]        in_op,
  input  wire logic [SLOT_W-1:0]      in_slot,
  input  wire logic [DEST_W-1:0]      in_dest,
  input  wire logic [PAYLOAD_W-1:0]   in_payload,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CNT_W-1:0]       cfg_wr_data,
  input  wire irp_cmd_t               cmd,
  output irp_stat_t                   stat,
  input  wire logic                   out_tready,
  output logic                        out_tvalid,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // Captured item
  op_t                     op_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [DEST_W-1:0]       dest_r;
  logic [PAYLOAD_BITS-1:0] payload_r;

  // Walk state
  logic [N_W-1:0]          idx_r;
  logic [IDX_W-1:0]        d_r;
  logic [PAYLOAD_BITS-1:0] cur_r;

  logic [CNT_W-1:0]        node_count_r;
  logic                    out_tvalid_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;

  logic [N_W-1:0]          nc_ext;
  logic [N_W-1:0]          n_eff;
  logic [N_W-1:0]          dq_ext;
  logic [IDX_W-1:0]        raddr;
  logic [IDX_W-1:0]        waddr;
  logic [PAYLOAD_BITS-1:0] rec_wdata;
  logic [PAYLOAD_BITS-1:0] rec_q;
  logic [DEST_W-1:0]       dest_q;
  logic                    seen_q;
  logic [PAYLOAD_W-1:0]    res_payload;

  function automatic logic [IDX_W-1:0] addr_of(input logic [N_W-1:0] v);
    return v[IDX_W-1:0];
  endfunction

  // Active slot count, clamped to the store depth
  always_comb begin
    nc_ext = N_W'(node_count_r);
    n_eff  = (nc_ext > N_W'(DEPTH)) ? N_W'(DEPTH) : nc_ext;
    dq_ext = N_W'(dest_q);
  end

  // Address and write data selection
  always_comb begin
    case (cmd.rd_sel)
      RD_IN:     raddr = addr_of(N_W'(in_slot));
      RD_ITEM:   raddr = addr_of(N_W'(slot_r));
      RD_IDX:    raddr = addr_of(idx_r);
      RD_D:      raddr = d_r;
      RD_DEST_Q: raddr = addr_of(dq_ext);
      default:   raddr = addr_of(idx_r);
    endcase
    case (cmd.wr_sel)
      WR_ITEM: waddr = addr_of(N_W'(slot_r));
      WR_IDX:  waddr = addr_of(idx_r);
      WR_D:    waddr = d_r;
      default: waddr = addr_of(idx_r);
    endcase
    rec_wdata = cmd.rec_wcur ? cur_r : payload_r;
  end

  irp_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (cmd.rec_we),
    .waddr (waddr),
    .wdata (rec_wdata),
    .raddr (raddr),
    .rdata (rec_q)
  );

  irp_ram #(.WIDTH(DEST_W), .DEPTH(DEPTH)) u_dest_ram (
    .clk   (clk),
    .we    (cmd.dest_we),
    .waddr (waddr),
    .wdata (dest_r),
    .raddr (raddr),
    .rdata (dest_q)
  );

  irp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen_ram (
    .clk   (clk),
    .we    (cmd.seen_we),
    .waddr (waddr),
    .wdata (cmd.seen_wdata),
    .raddr (raddr),
    .rdata (seen_q)
  );

  // Item capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= op_t'(in_op);
      slot_r    <= in_slot;
      dest_r    <= in_dest;
      payload_r <= in_payload[PAYLOAD_BITS-1:0];
    end
    if (cmd.d_load) begin
      d_r <= addr_of(dq_ext);
    end
    if (cmd.cur_load) begin
      cur_r <= rec_q;
    end
  end

  // Slot counter and node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      node_count_r <= NODE_COUNT_RST;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + N_W'(1);
      end
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
  end

  // Result payload: zero-extended record read data, else zero
  always_comb begin
    res_payload = '0;
    if (cmd.res_use_rec) begin
      res_payload[PAYLOAD_BITS-1:0] = rec_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_tdata_r <= OUT_TDATA_W'({cmd.res_status, res_payload});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Status to the controller
  always_comb begin
    stat.op           = op_r;
    stat.slot_oob     = N_W'(slot_r) >= n_eff;
    stat.dest_oob     = N_W'(dest_r) >= n_eff;
    stat.idx_at_n     = idx_r == n_eff;
    stat.idx_at_depth = idx_r == N_W'(DEPTH);
    stat.dq_oob       = dq_ext >= n_eff;
    stat.dq_eq_idx    = dq_ext == idx_r;
    stat.seen_q       = seen_q;
    stat.out_free     = !out_tvalid_r || out_tready;
  end

endmodule

`default_nettype wire

@@ hw/rtl/irp_ctrl.sv @@
// Controller: sequences single-slot words, the permutation check, clear sweeps and cycle walks.
`default_nettype none

module irp_ctrl
  import irp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire irp_stat_t stat,
  output irp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_OP,
    S_CK_RD,
    S_CK_DEST,
    S_CK_SEEN,
    S_CLR,
    S_MV_RD,
    S_MV_LEAD,
    S_MV_STEP_RD,
    S_MV_STEP,
    S_MV_CLOSE,
    S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  status_t err_r, err_nxt;
  logic    moved_r, moved_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    moved_nxt = moved_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.rd_sel     = RD_IDX;
    cmd.wr_sel     = WR_IDX;
    cmd.res_status = ST_OK;

    case (state_r)
      // clear the seen store after reset
      S_INIT: begin
        if (stat.idx_at_depth) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.seen_we = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end

      // read address follows the incoming slot so data is ready next cycle
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.rd_sel = RD_IN;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_OP;
        end
      end

      S_OP: begin
        cmd.rd_sel = RD_ITEM;
        cmd.wr_sel = WR_ITEM;
        if (stat.op == OP_PERMUTE) begin
          cmd.idx_clr = 1'b1;
          err_nxt     = ST_OK;
          moved_nxt   = 1'b0;
          state_nxt   = S_CK_RD;
        end else if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
          case (stat.op)
            OP_LOAD: begin
              if (stat.slot_oob) begin
                cmd.res_status = ST_SLOT_RANGE;
              end else begin
                cmd.rec_we     = 1'b1;
                cmd.dest_we    = 1'b1;
                cmd.res_status = stat.dest_oob ? ST_DEST_RANGE : ST_OK;
              end
            end
            OP_READ: begin
              cmd.res_status  = stat.slot_oob ? ST_SLOT_RANGE : ST_OK;
              cmd.res_use_rec = !stat.slot_oob;
            end
            default: cmd.res_status = ST_OK;
          endcase
        end
      end

      // check: fetch destination of slot idx
      S_CK_RD: begin
        if (stat.idx_at_n) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          state_nxt = S_CK_DEST;
        end
      end

      // check: range test, then fetch seen bit of that destination
      S_CK_DEST: begin
        if (stat.dq_oob) begin
          err_nxt     = ST_DEST_RANGE;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          cmd.rd_sel = RD_DEST_Q;
          cmd.d_load = 1'b1;
          state_nxt  = S_CK_SEEN;
        end
      end

      S_CK_SEEN: begin
        if (stat.seen_q) begin
          err_nxt     = ST_DUP;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          cmd.wr_sel     = WR_D;
          cmd.seen_we    = 1'b1;
          cmd.seen_wdata = 1'b1;
          cmd.idx_inc    = 1'b1;
          state_nxt      = S_CK_RD;
        end
      end

      // sweep seen bits of the active slots back to zero
      S_CLR: begin
        if (stat.idx_at_n) begin
          cmd.idx_clr = 1'b1;
          if (err_r != ST_OK || moved_r) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_MV_RD;
          end
        end else begin
          cmd.seen_we = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end

      // move: fetch record, destination and seen bit of leader candidate
      S_MV_RD: begin
        if (stat.idx_at_n) begin
          cmd.idx_clr = 1'b1;
          moved_nxt   = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          state_nxt = S_MV_LEAD;
        end
      end

      S_MV_LEAD: begin
        if (stat.seen_q) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_MV_RD;
        end else begin
          cmd.seen_we    = 1'b1;
          cmd.seen_wdata = 1'b1;
          cmd.cur_load   = 1'b1;
          cmd.d_load     = 1'b1;
          if (stat.dq_eq_idx) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_MV_RD;
          end else begin
            state_nxt = S_MV_STEP_RD;
          end
        end
      end

      S_MV_STEP_RD: begin
        cmd.rd_sel = RD_D;
        state_nxt  = S_MV_STEP;
      end

      // drop carried record at d, pick up the one that was there
      S_MV_STEP: begin
        cmd.wr_sel     = WR_D;
        cmd.rec_we     = 1'b1;
        cmd.rec_wcur   = 1'b1;
        cmd.seen_we    = 1'b1;
        cmd.seen_wdata = 1'b1;
        cmd.cur_load   = 1'b1;
        cmd.d_load     = 1'b1;
        state_nxt      = stat.dq_eq_idx ? S_MV_CLOSE : S_MV_STEP_RD;
      end

      // cycle closes on its leader slot
      S_MV_CLOSE: begin
        cmd.rec_we   = 1'b1;
        cmd.rec_wcur = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_MV_RD;
      end

      S_FIN: begin
        if (stat.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = err_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      err_r   <= ST_OK;
      moved_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
      moved_r <= moved_nxt;
    end
  end

endmodule

`default_nettype wire

@@ dv/in_place_record_permuter_top_tb.sv @@
// Self-checking stream testbench for the in-place record permuter: shadow store, random traffic.
module in_place_record_permuter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irp_pkg::*;

  // Longest stretch with no word moving is the seen-store clear after reset or the
  // clear sweep of a full-depth reject; allow several times that
  localparam int QUIET_LIMIT  = 6000;
  localparam int SETTLE_WORDS = 16;
  localparam int RANDOM_WORDS = 800;

  typedef struct {
    op_t                  op;
    logic [SLOT_W-1:0]    slot;
    logic [DEST_W-1:0]    dest;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_word_t;

  typedef struct {
    logic [PAYLOAD_W-1:0] payload;
    status_t              status;
  } result_word_t;

  typedef int idx_list_t[$];

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [OP_W-1:0]        in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;

  in_place_record_permuter_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stimulus side
  cmd_word_t    pending_words[$];
  result_word_t awaited_results[$];
  bit           loaded[DEPTH];      // slots the stimulus has already filled
  int           gen_slots = DEPTH;  // effective node count as the stimulus sees it
  int           words_queued;
  int           random_words;
  bit           in_throttle;
  bit           out_throttle;
  int           in_gap;
  int           out_gap;

  // Checker side
  logic [PAYLOAD_W-1:0] shadow_records[DEPTH];
  logic [DEST_W-1:0]    shadow_dests[DEPTH];
  logic [CNT_W-1:0]     shadow_node_count;
  bit                   in_acc;
  int                   words_accepted;
  int                   words_checked;
  int                   errors;
  int                   quiet_cycles;
  int                   loads_seen, reads_seen, permutes_seen, permutes_rejected;
  int                   settings_used;

  // Apply one command word to the shadow store and return the word the block must answer
  function automatic result_word_t execute_on_shadow(cmd_word_t w);
    bit                   claimed[DEPTH];
    int                   n;
    int                   s;
    int                   d;
    int                   steps;
    logic [PAYLOAD_W-1:0] held;
    result_word_t         r;
    n = (shadow_node_count < DEPTH) ? int'(shadow_node_count) : DEPTH;
    r.payload = '0;
    r.status  = ST_OK;
    case (w.op)
      OP_LOAD: begin
        if (w.slot >= n) begin
          r.status = ST_SLOT_RANGE;
        end else begin
          shadow_records[w.slot] = w.payload;
          shadow_dests[w.slot]   = w.dest;
          if (w.dest >= n) r.status = ST_DEST_RANGE;
        end
      end
      OP_PERMUTE: begin
        // Order check: first slot with a bad destination decides the status
        for (s = 0; s < n && r.status == ST_OK; s++) begin
          d = shadow_dests[s];
          if (d >= n) r.status = ST_DEST_RANGE;
          else if (claimed[d]) r.status = ST_DUP;
          else claimed[d] = 1'b1;
        end
        if (r.status == ST_OK) begin
          foreach (claimed[i]) claimed[i] = 1'b0;
          // Walk each cycle once from its lowest slot, swapping records along it
          for (s = 0; s < n; s++) begin
            if (!claimed[s]) begin
              claimed[s] = 1'b1;
              d = shadow_dests[s];
              steps = 0;
              while (d != s && d < n && steps < n) begin
                held              = shadow_records[s];
                shadow_records[s] = shadow_records[d];
                shadow_records[d] = held;
                claimed[d]        = 1'b1;
                d = shadow_dests[d];
                steps++;
              end
            end
          end
        end
      end
      OP_READ: begin
        if (w.slot >= n) r.status = ST_SLOT_RANGE;
        else r.payload = shadow_records[w.slot];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Monitor: accept words, predict, check results, watchdog
  always @(posedge clk) begin
    cmd_word_t            taken;
    result_word_t         want;
    logic [PAYLOAD_W-1:0] got_payload;
    status_t              got_status;
    in_acc = 1'b0;
    if (!rst_n) begin
      shadow_node_count = NODE_COUNT_RST;
    end else begin
      if (cfg_wr_en) shadow_node_count = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        taken.op      = op_t'(in_tuser);
        taken.slot    = in_tdata[SLOT_W-1:0];
        taken.dest    = in_tdata[SLOT_W+DEST_W-1:SLOT_W];
        taken.payload = in_tdata[SLOT_W+DEST_W+PAYLOAD_W-1:SLOT_W+DEST_W];
        want = execute_on_shadow(taken);
        awaited_results.push_back(want);
        in_acc = 1'b1;
        words_accepted++;
        case (taken.op)
          OP_LOAD:    loads_seen++;
          OP_READ:    reads_seen++;
          OP_PERMUTE: begin
            permutes_seen++;
            if (want.status != ST_OK) permutes_rejected++;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got_payload = out_tdata[PAYLOAD_W-1:0];
        got_status  = status_t'(out_tdata[PAYLOAD_W+STATUS_W-1:PAYLOAD_W]);
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none awaited: expected nothing, got payload %h status %0d",
                   $time, got_payload, got_status);
        end else begin
          want = awaited_results.pop_front();
          if (got_payload !== want.payload) begin
            errors++;
            $display("%0t: read_payload mismatch on result %0d: expected %h, got %h",
                     $time, words_checked, want.payload, got_payload);
          end
          if (got_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch on result %0d: expected %0d, got %0d",
                     $time, words_checked, want.status, got_status);
          end
        end
        words_checked++;
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results still awaited",
               $time, quiet_cycles, awaited_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: next word and ready both change on the falling edge
  always @(negedge clk) begin
    cmd_word_t nxt;
    if (!in_tvalid || in_acc) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (in_throttle && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        nxt = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= {{(IN_TDATA_W-SLOT_W-DEST_W-PAYLOAD_W){1'b0}},
                      nxt.payload, nxt.dest, nxt.slot};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (out_throttle && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void queue_word(op_t op, int slot, int dest, logic [PAYLOAD_W-1:0] pay);
    cmd_word_t w;
    w.op      = op;
    w.slot    = slot[SLOT_W-1:0];
    w.dest    = dest[DEST_W-1:0];
    w.payload = pay;
    pending_words.push_back(w);
    words_queued++;
    if (op != OP_NOP) random_words++;
    if (op == OP_LOAD && slot < gen_slots) loaded[slot] = 1'b1;
  endfunction

  function automatic idx_list_t shuffled_slots(int n);
    idx_list_t q;
    int        j;
    int        t;
    for (int i = 0; i < n; i++) q.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  // Fill every active slot in shuffled order; flaw 1 repeats a destination,
  // flaw 2 points one slot to a destination at or past the node count
  function automatic void load_order(int n, int flaw);
    idx_list_t dests;
    idx_list_t order;
    int        a;
    dests = shuffled_slots(n);
    order = shuffled_slots(n);
    a = (n > 0) ? $urandom_range(0, n - 1) : 0;
    if (flaw == 1 && n >= 2) dests[a] = dests[(a + $urandom_range(1, n - 1)) % n];
    else if (flaw == 2 && n < DEPTH) dests[a] = $urandom_range(n, DEPTH - 1);
    foreach (order[k]) queue_word(OP_LOAD, order[k], dests[order[k]], {$urandom, $urandom});
  endfunction

  // Only permute once every active slot holds a record and a destination
  function automatic void queue_permute();
    for (int s = 0; s < gen_slots; s++) if (!loaded[s]) return;
    queue_word(OP_PERMUTE, $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1),
               {$urandom, $urandom});
  endfunction

  function automatic void read_some(int cnt);
    int s;
    repeat (cnt) begin
      s = $urandom_range(0, DEPTH - 1);
      if (gen_slots > 0 && $urandom_range(0, 5) != 0) s = $urandom_range(0, gen_slots - 1);
      if (s >= gen_slots || loaded[s])
        queue_word(OP_READ, s, $urandom_range(0, DEPTH - 1), {$urandom, $urandom});
    end
  endfunction

  // Out-of-range loads and reads, and no-ops, none of which touch the store
  function automatic void add_noise(int cnt);
    int s;
    repeat (cnt) begin
      s = $urandom_range(0, DEPTH - 1);
      if (s < gen_slots)
        queue_word(OP_NOP, s, $urandom_range(0, DEPTH - 1), {$urandom, $urandom});
      else if ($urandom_range(0, 1) == 0)
        queue_word(OP_LOAD, s, $urandom_range(0, DEPTH - 1), {$urandom, $urandom});
      else
        queue_word(OP_READ, s, $urandom_range(0, DEPTH - 1), {$urandom, $urandom});
    end
  endfunction

  task automatic wait_drained();
    while (words_accepted != words_queued || awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_WORDS) @(negedge clk);
  endtask

  task automatic set_node_count(logic [CNT_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    gen_slots = (v > DEPTH) ? DEPTH : int'(v);
    settings_used++;
  endtask

  initial begin
    int n;
    int pick;
    int flaw;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes at the reset node count
    in_throttle  = 1'b1;
    out_throttle = 1'b1;
    queue_word(OP_LOAD, 0, DEPTH - 1, '1);
    queue_word(OP_LOAD, DEPTH - 1, 0, '0);
    queue_word(OP_LOAD, 512, 512, 64'h8000_0000_0000_0001);
    queue_word(OP_READ, 0, 0, '0);
    queue_word(OP_READ, DEPTH - 1, DEPTH - 1, '1);
    queue_word(OP_READ, 512, 0, '0);
    queue_word(OP_NOP, DEPTH - 1, DEPTH - 1, '1);

    // Directed: three slots; slot and destination range, duplicate, then a rotation
    set_node_count(3);
    queue_word(OP_LOAD, 3, 0, '1);
    queue_word(OP_READ, DEPTH - 1, 0, '0);
    queue_word(OP_LOAD, 0, 1, 64'h0123_4567_89ab_cdef);
    queue_word(OP_LOAD, 1, 1, 64'hfedc_ba98_7654_3210);
    queue_word(OP_LOAD, 2, 3, 64'h5555_aaaa_5555_aaaa);
    queue_word(OP_PERMUTE, 0, 0, '0);
    queue_word(OP_LOAD, 1, 5, 64'hfedc_ba98_7654_3210);
    queue_word(OP_PERMUTE, 0, 0, '0);
    queue_word(OP_LOAD, 1, 2, 64'hfedc_ba98_7654_3210);
    queue_word(OP_LOAD, 2, 0, 64'h5555_aaaa_5555_aaaa);
    queue_word(OP_PERMUTE, 0, 0, '0);
    read_some(3);

    // Directed: zero node count, then a single slot
    set_node_count(0);
    queue_word(OP_LOAD, 0, 0, '1);
    queue_word(OP_READ, 0, 0, '0);
    queue_permute();
    set_node_count(1);
    queue_word(OP_LOAD, 0, 0, {$urandom, $urandom});
    queue_permute();
    queue_word(OP_READ, 0, 0, '0);

    // Full depth, with a count above the store size; a repeated destination in
    // the first two slots is rejected before any unloaded slot is checked
    set_node_count(11'h7ff);
    queue_word(OP_LOAD, DEPTH - 1, DEPTH - 1, {$urandom, $urandom});
    queue_word(OP_LOAD, 0, 5, {$urandom, $urandom});
    queue_word(OP_LOAD, 1, 5, {$urandom, $urandom});
    queue_word(OP_PERMUTE, 0, 0, '0);
    queue_word(OP_READ, DEPTH - 1, 0, '0);
    read_some(8);

    // Random phases: mostly well-formed load/permute/read runs at small node counts
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) n = $urandom_range(1, 8);
      else if (pick < 9) n = $urandom_range(9, 48);
      else n = $urandom_range(1, 2);
      set_node_count(n);
      if (random_words > RANDOM_WORDS * 85 / 100) begin
        in_throttle  = 1'b0;
        out_throttle = 1'b0;
      end else begin
        in_throttle  = ($urandom_range(0, 3) != 0);
        out_throttle = ($urandom_range(0, 3) != 0);
      end
      flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      load_order(n, flaw);
      add_noise($urandom_range(0, 2));
      queue_permute();
      read_some($urandom_range(1, n + 2));
      if ($urandom_range(0, 1) == 0) begin
        queue_permute();
        read_some($urandom_range(1, 4));
      end
      add_noise($urandom_range(0, 3));
    end
    set_node_count(NODE_COUNT_RST);
    read_some(4);

    wait_drained();
    $display("Covered %0d loads, %0d reads and %0d permutes (%0d rejected by the order check)",
             loads_seen, reads_seen, permutes_seen, permutes_rejected);
    $display("over %0d node-count settings; %0d result words checked, %0d mismatches",
             settings_used, words_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/irp_pkg.sv
hw/rtl/irp_ram.sv
hw/rtl/irp_dpath.sv
hw/rtl/irp_ctrl.sv
hw/rtl/in_place_record_permuter_top.sv
dv/in_place_record_permuter_top_tb.sv
